// File: rtl/rvbp_pkg.sv
// Shared types, opcode and mode codes, and immediate decoders for the branch predictor.
`default_nettype none

package rvbp_pkg;

    // Default sizing
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int INDEX_SHIFT_DEF   = 2;

    // Opcode field
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    // Request codes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Predictor modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_STATIC_NT = 2'd0;
    localparam t_mode MODE_BTFN      = 2'd1;
    localparam t_mode MODE_ONE_BIT   = 2'd2;
    localparam t_mode MODE_TWO_BIT   = 2'd3;

    // Table reset values and counter bounds
    localparam logic       LAST_OUTCOME_RST = 1'b0;
    localparam logic [1:0] COUNTER_RST      = 2'b01;
    localparam logic [1:0] COUNTER_MAX      = 2'b11;
    localparam logic [1:0] COUNTER_MIN      = 2'b00;

    typedef struct packed {
        logic        operation;
        logic [63:0] pc;
        logic [31:0] instruction;
        logic        taken_resolved;
    } t_bp_req;

    typedef struct packed {
        logic        taken_guess;
        logic [63:0] target_guess;
        logic [31:0] prediction_count;
        logic [31:0] correct_count;
    } t_bp_rsp;

    // B-type immediate, sign extended to 64 bits
    function automatic logic [63:0] b_imm(input logic [31:0] w);
        b_imm = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    endfunction

    // J-type immediate, sign extended to 64 bits
    function automatic logic [63:0] j_imm(input logic [31:0] w);
        j_imm = {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    endfunction

endpackage

`default_nettype wire

// File: rtl/riscv_branch_predictor.sv
// Bimodal branch predictor: request stage with table read, result register, table clear sweep.
// Path: an accepted request is held in stage one, then loaded into the result register when it is free.
// Throughput: one request per cycle while no clear runs and the result is not stalled; each
// table is a one-write, one-read memory whose read is registered at accept and forwarded from the
// write in flight. Reset: counters clear and mode goes to two-bit; then a sweep writes the table
// reset values to every entry, during which the request side is stalled.
// TABLE_ENTRIES must be a power of two (the block does not check it); the index is pc bits above INDEX_SHIFT.
`default_nettype none

module riscv_branch_predictor #(
    parameter int TABLE_ENTRIES = rvbp_pkg::TABLE_ENTRIES_DEF,
    parameter int INDEX_SHIFT   = rvbp_pkg::INDEX_SHIFT_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration write
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  rvbp_pkg::t_mode        i_cfg_data,
    // Request channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  rvbp_pkg::t_bp_req      i_in_data,
    // Result channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output rvbp_pkg::t_bp_rsp      o_out_data
);
    import rvbp_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Tables
    logic             lob_mem [TABLE_ENTRIES];
    logic [1:0]       ctr_mem [TABLE_ENTRIES];

    // Control and state registers
    t_mode            r_mode;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;
    logic             r_s1_valid;
    t_bp_req          r_s1_req;
    logic             r_lob_rd;
    logic [1:0]       r_ctr_rd;
    logic [31:0]      r_pred_total;
    logic [31:0]      r_corr_total;
    logic             r_out_valid;
    t_bp_rsp          r_out_data;

    // Combinational
    logic             in_acc;
    logic             s1_adv;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] s1_idx;
    logic [IDX_W-1:0] w_idx;
    logic             lob_we;
    logic             lob_wd;
    logic             ctr_we;
    logic [1:0]       ctr_wd;
    logic [6:0]       opc;
    logic             is_jal;
    logic             is_jalr;
    logic             is_br;
    logic             guess;
    logic             is_pred;
    logic             br_upd;
    logic [63:0]      tgt_sum;
    logic [1:0]       ctr_next;
    logic [31:0]      n_pred_total;
    logic [31:0]      n_corr_total;
    t_bp_rsp          n_out_data;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_idx = i_in_data.pc[INDEX_SHIFT +: IDX_W];
    assign s1_idx = r_s1_req.pc[INDEX_SHIFT +: IDX_W];

    // Decode the request in stage one
    assign opc     = r_s1_req.instruction[6:0];
    assign is_jal  = (opc == OPC_JAL);
    assign is_jalr = (opc == OPC_JALR);
    assign is_br   = (opc == OPC_BRANCH);
    assign is_pred = (r_s1_req.operation == OP_PREDICT);
    assign br_upd  = !is_pred && is_br;

    // Policy guess for a conditional branch
    always_comb begin
        unique case (r_mode)
            MODE_STATIC_NT: guess = 1'b0;
            MODE_BTFN:      guess = r_s1_req.instruction[31];
            MODE_ONE_BIT:   guess = r_lob_rd;
            MODE_TWO_BIT:   guess = r_ctr_rd[1];
            default:        guess = 1'b0;
        endcase
    end

    // Target adder, shared by JAL and conditional branch
    assign tgt_sum = r_s1_req.pc + (is_jal ? j_imm(r_s1_req.instruction)
                                           : b_imm(r_s1_req.instruction));

    // Saturating counter step
    always_comb begin
        priority if (r_s1_req.taken_resolved && r_ctr_rd == COUNTER_MAX) begin
            ctr_next = COUNTER_MAX;
        end else if (!r_s1_req.taken_resolved && r_ctr_rd == COUNTER_MIN) begin
            ctr_next = COUNTER_MIN;
        end else if (r_s1_req.taken_resolved) begin
            ctr_next = r_ctr_rd + 2'd1;
        end else begin
            ctr_next = r_ctr_rd - 2'd1;
        end
    end

    // Counts after this request
    assign n_pred_total = r_pred_total + {31'd0, is_pred && is_br};
    assign n_corr_total = r_corr_total
                        + {31'd0, br_upd && (guess == r_s1_req.taken_resolved)};

    // Result
    always_comb begin
        n_out_data.taken_guess      = is_pred && (is_jal || is_jalr || (is_br && guess));
        n_out_data.target_guess     = (is_pred && (is_jal || (is_br && guess))) ? tgt_sum
                                                                               : 64'd0;
        n_out_data.prediction_count = n_pred_total;
        n_out_data.correct_count    = n_corr_total;
    end

    // Table write port: clear sweep or training
    always_comb begin
        if (r_clr_busy) begin
            w_idx  = r_clr_idx;
            lob_we = 1'b1;
            lob_wd = LAST_OUTCOME_RST;
            ctr_we = 1'b1;
            ctr_wd = COUNTER_RST;
        end else begin
            w_idx  = s1_idx;
            lob_we = s1_adv && br_upd && (r_mode == MODE_ONE_BIT);
            lob_wd = r_s1_req.taken_resolved;
            ctr_we = s1_adv && br_upd && (r_mode == MODE_TWO_BIT);
            ctr_wd = ctr_next;
        end
    end

    // Last-outcome table: write, read at accept with forwarding
    always_ff @(posedge i_clk) begin
        if (lob_we) begin
            lob_mem[w_idx] <= lob_wd;
        end
        if (in_acc) begin
            r_lob_rd <= (lob_we && w_idx == in_idx) ? lob_wd : lob_mem[in_idx];
        end
    end

    // Counter table: write, read at accept with forwarding
    always_ff @(posedge i_clk) begin
        if (ctr_we) begin
            ctr_mem[w_idx] <= ctr_wd;
        end
        if (in_acc) begin
            r_ctr_rd <= (ctr_we && w_idx == in_idx) ? ctr_wd : ctr_mem[in_idx];
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TWO_BIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage one: hold the request, advance on a free result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req <= i_in_data;
        end
    end

    // Running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_total <= '0;
            r_corr_total <= '0;
        end else if (s1_adv) begin
            r_pred_total <= n_pred_total;
            r_corr_total <= n_corr_total;
        end
    end

    // Result register: load on advance, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // Checks
    a_clr_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("request taken during table clear");

    a_clr_empty_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_valid)
        else $error("stage one busy during table clear");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("stage one lost a request while result stalled");

    a_totals_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> ($stable(r_pred_total) && $stable(r_corr_total)))
        else $error("totals moved without a request advancing");

    a_no_train_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_busy && !s1_adv) |-> (!lob_we && !ctr_we))
        else $error("table written without a request advancing");

endmodule

`default_nettype wire
